### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KSCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KSCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kscd_pkg.sv
package kscd_pkg;

    localparam logic [7:0] CMD_SET_LEDS = 8'hED;
    localparam logic [7:0] RSP_ACK      = 8'hFA;
    localparam logic [7:0] RSP_RESEND   = 8'hFE;
    localparam logic [7:0] SC_LSHIFT_MK = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_NUM       = 8'h45;
    localparam logic [7:0] SC_SCROLL    = 8'h46;
    localparam logic [6:0] CASE_OFFSET  = 7'h20;
    localparam logic [6:0] ASCII_UC_A   = 7'h41;
    localparam logic [6:0] ASCII_UC_Z   = 7'h5A;
    localparam logic [2:0] LED_CAPS     = 3'b100;
    localparam logic [2:0] LED_NUM      = 3'b010;
    localparam logic [2:0] LED_SCROLL   = 3'b001;

    // one LED command: 0xED always first, then the LED byte if it fit
    typedef struct packed {
        logic       has_leds;
        logic [2:0] leds;
    } t_cmd_rec;

    typedef struct packed {
        logic       reload;
        logic [2:0] reload_leds;
        logic       push;
        logic [2:0] push_leds;
        logic       pop;
    } t_q_ctl;

    typedef struct packed {
        logic       ed_ok;
        logic       leds_ok;
        logic       avail;
        logic [7:0] head_byte;
    } t_q_stat;

    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h10: ch = 7'h51;
            7'h11: ch = 7'h57;
            7'h12: ch = 7'h45;
            7'h13: ch = 7'h52;
            7'h14: ch = 7'h54;
            7'h15: ch = 7'h59;
            7'h16: ch = 7'h55;
            7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h41;
            7'h1F: ch = 7'h53;
            7'h20: ch = 7'h44;
            7'h21: ch = 7'h46;
            7'h22: ch = 7'h47;
            7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A;
            7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h5A;
            7'h2D: ch = 7'h58;
            7'h2E: ch = 7'h43;
            7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42;
            7'h31: ch = 7'h4E;
            7'h32: ch = 7'h4D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            7'h47: ch = 7'h37;
            7'h48: ch = 7'h38;
            7'h49: ch = 7'h39;
            7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34;
            7'h4C: ch = 7'h35;
            7'h4D: ch = 7'h36;
            7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31;
            7'h50: ch = 7'h32;
            7'h51: ch = 7'h33;
            7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // only the keys whose shifted glyph differs; the rest match the plain map
    function automatic logic [6:0] shifted_char(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;
            7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;
            7'h1A: ch = 7'h7B;
            7'h1B: ch = 7'h7D;
            7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;
            default: ch = plain_char(code);
        endcase
        return ch;
    endfunction

endpackage

### rtl/keyboard_scan_code_decoder.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready     tdata: scan_code
// m_axis    out  m_axis_tvalid/m_axis_tready     tuser: char_valid, tx_valid
//                                                tdata: char_code, tx_byte, led_state,
//                                                       queue_dropped
// cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_data: initial_leds
//
// One byte per cycle while m_axis accepts; each byte passes the input register, then the result register.
// Each byte is registered, decoded and state-updated in one pass, then held in the
// result register; the command queue memory has one write and one registered read.
// Reset (i_rst_n, synchronous) clears LEDs and shift state and loads the queue with
// 0xED, 0x00; a config write loads LEDs from i_cfg_data and the queue with 0xED and that LED byte.
// A stalled m_axis holds the result; s_axis keeps accepting while the input stage
// is free.
module keyboard_scan_code_decoder #(
    parameter int CMD_QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] char_code, [14:7] tx_byte,
                                        // [17:15] led_state, [18] queue_dropped
    output logic [1:0]  m_axis_tuser    // [0] char_valid, [1] tx_valid
);

`include "assert_macros.svh"

    logic              r_in_valid;
    logic [7:0]        r_in_code;
    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic [1:0]        r_out_user;

    logic [1:0]        r_shift, n_shift;
    logic [2:0]        r_leds, n_leds;
    logic              r_pend_valid, n_pend_valid;
    logic [7:0]        r_pend_byte, n_pend_byte;

    logic              w_cfg_we;
    logic              w_adv;
    logic              w_fire;
    logic [2:0]        w_toggle;
    logic              w_ack;
    logic              w_resend;
    logic              w_pend_kept;
    logic              w_pop;
    logic              w_tx_valid;
    logic [7:0]        w_tx_byte;
    logic              w_dropped;
    logic              w_char_valid;
    logic [6:0]        w_char_code;

    kscd_pkg::t_q_ctl  w_qctl;
    kscd_pkg::t_q_stat w_qstat;

    assign o_cfg_ready   = 1'b1;
    assign w_cfg_we      = i_cfg_valid && o_cfg_ready;
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    kscd_char_map u_char_map (
        .i_code       (r_in_code),
        .i_shift      (r_shift != 2'b00),
        .i_caps       (r_leds[2]),
        .o_char_valid (w_char_valid),
        .o_char_code  (w_char_code)
    );

    always_comb begin
        n_shift  = r_shift;
        w_toggle = 3'b000;
        case (r_in_code)
            kscd_pkg::SC_LSHIFT_MK: n_shift  = r_shift | 2'b01;
            kscd_pkg::SC_RSHIFT_MK: n_shift  = r_shift | 2'b10;
            kscd_pkg::SC_LSHIFT_BR: n_shift  = r_shift & 2'b10;
            kscd_pkg::SC_RSHIFT_BR: n_shift  = r_shift & 2'b01;
            kscd_pkg::SC_CAPS:      w_toggle = kscd_pkg::LED_CAPS;
            kscd_pkg::SC_NUM:       w_toggle = kscd_pkg::LED_NUM;
            kscd_pkg::SC_SCROLL:    w_toggle = kscd_pkg::LED_SCROLL;
            default:                w_toggle = 3'b000;
        endcase
    end

    assign w_ack       = (r_in_code == kscd_pkg::RSP_ACK);
    assign w_resend    = (r_in_code == kscd_pkg::RSP_RESEND) && r_pend_valid;
    assign n_leds      = r_leds ^ w_toggle;
    assign w_pend_kept = r_pend_valid && !w_ack;
    assign w_pop       = w_fire && !w_pend_kept && w_qstat.avail;

    assign w_qctl.reload      = w_cfg_we;
    assign w_qctl.reload_leds = i_cfg_data;
    assign w_qctl.push        = w_fire && (w_toggle != 3'b000);
    assign w_qctl.push_leds   = n_leds;
    assign w_qctl.pop         = w_pop;

    kscd_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .o_stat  (w_qstat)
    );

    assign w_dropped    = (w_toggle != 3'b000) && !w_qstat.leds_ok;
    assign w_tx_valid   = w_resend || w_pop;
    assign w_tx_byte    = w_pop ? w_qstat.head_byte : (w_resend ? r_pend_byte : 8'h00);
    assign n_pend_valid = w_pop || w_pend_kept;
    assign n_pend_byte  = w_pop ? w_qstat.head_byte : r_pend_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_code <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= 2'b00;
            r_leds       <= 3'b000;
            r_pend_valid <= 1'b0;
        end else if (w_cfg_we) begin
            r_leds       <= i_cfg_data;
            r_pend_valid <= 1'b0;
        end else if (w_fire) begin
            r_shift      <= n_shift;
            r_leds       <= n_leds;
            r_pend_valid <= n_pend_valid;
        end
        if (w_fire) begin
            r_pend_byte <= n_pend_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_data <= {5'b0, w_dropped, n_leds, w_tx_byte, w_char_code};
            r_out_user <= {w_tx_valid, w_char_valid};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `KSCD_ASSERT_IMP(a_ready_when_free, !r_out_valid, s_axis_tready, "input stalled with free output")
    `KSCD_ASSERT_NXT(a_pop_sets_pend, w_pop && !w_cfg_we, r_pend_valid, "sent byte not pending")
    `KSCD_ASSERT_IMP(a_tx_one_source, w_fire, !(w_pop && w_resend), "pop and resend together")

endmodule

### rtl/kscd_char_map.sv
module kscd_char_map (
    input  logic [7:0] i_code,
    input  logic       i_shift,
    input  logic       i_caps,
    output logic       o_char_valid,
    output logic [6:0] o_char_code
);

    logic [6:0] w_base;
    logic       w_letter;

    always_comb begin
        if (i_code[7]) begin
            w_base = 7'h00;
        end else if (i_shift) begin
            w_base = kscd_pkg::shifted_char(i_code[6:0]);
        end else begin
            w_base = kscd_pkg::plain_char(i_code[6:0]);
        end
    end

    assign w_letter = (w_base >= kscd_pkg::ASCII_UC_A) && (w_base <= kscd_pkg::ASCII_UC_Z);

    assign o_char_code  = (w_letter && (i_caps == i_shift)) ? w_base + kscd_pkg::CASE_OFFSET
                                                             : w_base;
    assign o_char_valid = (o_char_code != 7'h00);

endmodule

### rtl/kscd_cmd_queue.sv
`include "assert_macros.svh"

module kscd_cmd_queue #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kscd_pkg::t_q_ctl   i_ctl,
    output kscd_pkg::t_q_stat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // one record per LED command; byte count tracks the byte-level fill
    kscd_pkg::t_cmd_rec mem [DEPTH];

    logic [AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]      r_bcount, n_bcount;
    logic               r_off, n_off;
    kscd_pkg::t_cmd_rec r_q;
    logic               r_fwd;
    kscd_pkg::t_cmd_rec r_fwd_rec;

    logic               w_reload;
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [AW-1:0]      w_ra;
    kscd_pkg::t_cmd_rec w_wd;
    kscd_pkg::t_cmd_rec w_push_rec;
    kscd_pkg::t_cmd_rec w_head;
    logic               w_ed_ok;
    logic               w_leds_ok;
    logic [CW-1:0]      w_cnt_push;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_reload  = !i_rst_n || i_ctl.reload;
    assign w_ed_ok   = r_bcount < CW'(DEPTH);
    assign w_leds_ok = r_bcount < CW'(DEPTH - 1);

    assign w_push_rec.has_leds = w_leds_ok;
    assign w_push_rec.leds     = i_ctl.push_leds;

    // empty queue: the head record is the one arriving now
    assign w_head = (r_bcount == '0) ? w_push_rec : (r_fwd ? r_fwd_rec : r_q);

    assign w_cnt_push = r_bcount + CW'(i_ctl.push && w_ed_ok) + CW'(i_ctl.push && w_leds_ok);

    assign o_stat.ed_ok     = w_ed_ok;
    assign o_stat.leds_ok   = w_leds_ok;
    assign o_stat.avail     = (w_cnt_push != '0);
    assign o_stat.head_byte = r_off ? {5'b0, w_head.leds} : kscd_pkg::CMD_SET_LEDS;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_off    = r_off;
        n_bcount = w_cnt_push;
        if (i_ctl.push && w_ed_ok) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end
        if (i_ctl.pop) begin
            n_bcount = w_cnt_push - 1'b1;
            if (!r_off && w_head.has_leds) begin
                n_off = 1'b1;
            end else begin
                n_off    = 1'b0;
                n_rd_ptr = ptr_inc(r_rd_ptr);
            end
        end
    end

    always_comb begin
        if (w_reload) begin
            w_we          = 1'b1;
            w_wa          = '0;
            w_ra          = '0;
            w_wd.has_leds = 1'b1;
            w_wd.leds     = i_rst_n ? i_ctl.reload_leds : 3'b000;
        end else begin
            w_we = i_ctl.push && w_ed_ok;
            w_wa = r_wr_ptr;
            w_ra = n_rd_ptr;
            w_wd = w_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_q       <= mem[w_ra];
        r_fwd     <= w_we && (w_wa == w_ra);
        r_fwd_rec <= w_wd;
    end

    always_ff @(posedge i_clk) begin
        if (w_reload) begin
            r_wr_ptr <= AW'(1);
            r_rd_ptr <= '0;
            r_bcount <= CW'(2);
            r_off    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_bcount <= n_bcount;
            r_off    <= n_off;
        end
    end

    `KSCD_ASSERT_IMP(a_cnt_max, 1'b1, r_bcount <= CW'(DEPTH), "byte count above depth")
    `KSCD_ASSERT_IMP(a_pop_avail, i_ctl.pop, o_stat.avail, "pop from empty queue")
    `KSCD_ASSERT_IMP(a_off_nonempty, r_off, r_bcount != '0, "LED byte offset on empty queue")

endmodule

### sim/testbench.sv
typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] led_state;
    logic       queue_dropped;
} t_key_out;

class t_key_scoreboard;
    int unsigned cmd_depth;
    bit [7:0]    plain_keys [128];
    bit [7:0]    shift_keys [128];
    bit [1:0]    shift_held;
    bit [2:0]    lock_leds;
    bit          cmd_pending;
    bit [7:0]    cmd_in_flight;
    bit [7:0]    led_cmds [$];
    t_key_out    expected_outs [$];
    int          failures;

    function new(int unsigned depth);
        string plain;
        string shifted;
        cmd_depth = depth;
        // z marks no character, b backspace, n newline
        plain = {"zz1234567890-=bzQWERTYUIOP[]nzASDFGHJKL;'`z\\ZXCV",
                 "BNM,./z*z zzzzzzzzzzzzz789-456+1230."};
        shifted = {"zz!@#$%^&*()_+bzQWERTYUIOP{}nzASDFGHJKL:\"~z|ZXCV",
                   "BNM<>?z*z zzzzzzzzzzzzz789-456+1230."};
        for (int i = 0; i < 128; i++) begin
            plain_keys[i] = (i < plain.len()) ? glyph(plain[i]) : 8'h00;
            shift_keys[i] = (i < shifted.len()) ? glyph(shifted[i]) : 8'h00;
        end
        shift_held = 2'b00;
        failures = 0;
        load_leds(3'd0);
    endfunction

    function bit [7:0] glyph(bit [7:0] c);
        case (c)
            "z": return 8'h00;
            "b": return 8'h08;
            "n": return 8'h0a;
            default: return c;
        endcase
    endfunction

    function void load_leds(bit [2:0] leds);
        lock_leds = leds;
        cmd_pending = 1'b0;
        cmd_in_flight = 8'h00;
        led_cmds.delete();
        led_cmds.push_back(kscd_pkg::CMD_SET_LEDS);
        led_cmds.push_back({5'b0, leds});
    endfunction

    function bit push_cmd(bit [7:0] cmd);
        if (led_cmds.size() >= cmd_depth) return 1'b0;
        led_cmds.push_back(cmd);
        return 1'b1;
    endfunction

    function void note_code(logic [7:0] code);
        t_key_out r;
        bit [7:0] ch;
        bit [2:0] flip;
        r = '0;
        ch = 8'h00;
        flip = 3'b000;
        if (!code[7]) begin
            ch = (shift_held != 0) ? shift_keys[code[6:0]] : plain_keys[code[6:0]];
            if (ch >= kscd_pkg::ASCII_UC_A && ch <= kscd_pkg::ASCII_UC_Z &&
                lock_leds[2] == (shift_held != 0))
                ch += kscd_pkg::CASE_OFFSET;
        end
        case (code)
            kscd_pkg::SC_LSHIFT_MK: shift_held[0] = 1'b1;
            kscd_pkg::SC_RSHIFT_MK: shift_held[1] = 1'b1;
            kscd_pkg::SC_LSHIFT_BR: shift_held[0] = 1'b0;
            kscd_pkg::SC_RSHIFT_BR: shift_held[1] = 1'b0;
            kscd_pkg::SC_CAPS:      flip = kscd_pkg::LED_CAPS;
            kscd_pkg::SC_NUM:       flip = kscd_pkg::LED_NUM;
            kscd_pkg::SC_SCROLL:    flip = kscd_pkg::LED_SCROLL;
            kscd_pkg::RSP_ACK:      cmd_pending = 1'b0;
            kscd_pkg::RSP_RESEND: begin
                if (cmd_pending) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = cmd_in_flight;
                end
            end
            default: ;
        endcase
        if (flip != 0) begin
            lock_leds ^= flip;
            if (!push_cmd(kscd_pkg::CMD_SET_LEDS)) r.queue_dropped = 1'b1;
            if (!push_cmd({5'b0, lock_leds})) r.queue_dropped = 1'b1;
        end
        if (!cmd_pending && led_cmds.size() > 0) begin
            cmd_in_flight = led_cmds.pop_front();
            cmd_pending = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = cmd_in_flight;
        end
        r.char_valid = (ch != 0);
        r.char_code = ch[6:0];
        r.led_state = lock_leds;
        expected_outs.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    function void check_output(logic [1:0] user, logic [23:0] data);
        t_key_out want;
        if (expected_outs.size() == 0) begin
            $error("result transfer with nothing expected: tuser %0h tdata %0h", user, data);
            failures++;
            return;
        end
        want = expected_outs.pop_front();
        cmp_field("char_valid", want.char_valid, user[0]);
        cmp_field("char_code", want.char_code, data[6:0]);
        cmp_field("tx_valid", want.tx_valid, user[1]);
        cmp_field("tx_byte", want.tx_byte, data[14:7]);
        cmp_field("led_state", want.led_state, data[17:15]);
        cmp_field("queue_dropped", want.queue_dropped, data[18]);
    endfunction
endclass

module testbench;
    localparam int CMD_DEPTH   = 32;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    t_key_scoreboard sb;
    bit              idle_on = 1'b1;
    bit              long_hold = 1'b0;
    int              codes_sent = 0;
    int              cycles = 0;

    keyboard_scan_code_decoder #(
        .CMD_QUEUE_DEPTH(CMD_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_code(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tuser, m_axis_tdata);
    end

    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_code(input logic [7:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        do @(posedge i_clk); while (!s_axis_tready);
        codes_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_outs.size() != 0) @(posedge i_clk);
    endtask

    // only while nothing is in flight
    task automatic write_leds(input logic [2:0] leds);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= leds;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.load_leds(leds);
    endtask

    function automatic logic [7:0] lock_key();
        case ($urandom_range(0, 2))
            0: return kscd_pkg::SC_CAPS;
            1: return kscd_pkg::SC_NUM;
            default: return kscd_pkg::SC_SCROLL;
        endcase
    endfunction

    task automatic run_random(input int n_items, input bit vary_idle);
        int stop;
        int kind;
        stop = codes_sent + n_items;
        while (codes_sent < stop) begin
            if (vary_idle && $urandom_range(0, 7) == 0) idle_on = !idle_on;
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 5) == 0) begin
                        case ($urandom_range(0, 3))
                            0: send_code(kscd_pkg::SC_LSHIFT_MK);
                            1: send_code(kscd_pkg::SC_RSHIFT_MK);
                            2: send_code(kscd_pkg::SC_LSHIFT_BR);
                            default: send_code(kscd_pkg::SC_RSHIFT_BR);
                        endcase
                    end else begin
                        send_code(8'($urandom_range(0, 127)));
                    end
                end
            end else if (kind < 12) begin
                // LED command exchange: toggle, then for each of the two bytes maybe a resend and usually an ack
                send_code(lock_key());
                repeat (2) begin
                    if ($urandom_range(0, 3) == 0) send_code(kscd_pkg::RSP_RESEND);
                    if ($urandom_range(0, 7) != 0) send_code(kscd_pkg::RSP_ACK);
                end
            end else if (kind < 14) begin
                repeat ($urandom_range(1, 3))
                    send_code($urandom_range(0, 1) ? kscd_pkg::RSP_ACK
                                                   : kscd_pkg::RSP_RESEND);
            end else if (kind == 14) begin
                // burst of toggles to overrun the command queue
                repeat ($urandom_range(10, 20)) send_code(lock_key());
                repeat ($urandom_range(0, 40)) send_code(kscd_pkg::RSP_ACK);
            end else begin
                repeat ($urandom_range(1, 4)) send_code(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [2:0] leds;
        sb = new(CMD_DEPTH);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_code(8'h1e);
        send_code(kscd_pkg::RSP_RESEND);
        send_code(kscd_pkg::RSP_ACK);
        send_code(kscd_pkg::RSP_ACK);
        send_code(kscd_pkg::RSP_ACK);
        send_code(kscd_pkg::RSP_RESEND);
        send_code(kscd_pkg::SC_LSHIFT_MK);
        send_code(8'h1e);
        send_code(8'h02);
        send_code(kscd_pkg::SC_RSHIFT_MK);
        send_code(kscd_pkg::SC_LSHIFT_BR);
        send_code(8'h29);
        send_code(kscd_pkg::SC_RSHIFT_BR);
        send_code(kscd_pkg::SC_CAPS);
        send_code(8'h1e);
        send_code(kscd_pkg::SC_LSHIFT_MK);
        send_code(8'h1e);
        send_code(kscd_pkg::SC_LSHIFT_BR);
        send_code(kscd_pkg::SC_NUM);
        send_code(kscd_pkg::SC_SCROLL);
        send_code(8'h00);
        send_code(8'h7f);
        send_code(8'h80);
        send_code(8'hff);
        send_code(8'h0e);
        send_code(8'h1c);
        send_code(8'h39);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: leds = 3'd7;
                1: leds = 3'd0;
                default: leds = 3'($urandom_range(0, 7));
            endcase
            write_leds(leds);
            idle_on = (ph != 5);
            if (ph == 2) long_hold = 1'b1;
            run_random(200, ph != 5);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_outs.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/kscd_pkg.sv
rtl/kscd_char_map.sv
rtl/kscd_cmd_queue.sv
rtl/keyboard_scan_code_decoder.sv
sim/testbench.sv
